// ===== rtl/cd_audio_drive_mixer_assert.svh =====
// ---------------------------------------------------------------------------
// cd_audio_drive_mixer_assert.svh
// Assertion macros for the optical drive audio mixer.
// ---------------------------------------------------------------------------
`ifndef CD_AUDIO_DRIVE_MIXER_ASSERT_SVH
`define CD_AUDIO_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while reset is low
`define CDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cd_audio_drive_mixer: assertion failed");

// Next-cycle implication
`define CDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cd_audio_drive_mixer: assertion failed");

`endif

// ===== rtl/cdm_pkg.sv =====
// ---------------------------------------------------------------------------
// cdm_pkg
// Shared types, constants and the log volume table of the drive mixer.
// ---------------------------------------------------------------------------
package cdm_pkg;

  // Number of drive ports on the block and number of drives actually mixed
  localparam int DRIVE_PORTS    = 4;
  localparam int DRIVE_COUNT    = 4;
  localparam int LANE_COUNT     = (DRIVE_COUNT < DRIVE_PORTS) ? DRIVE_COUNT : DRIVE_PORTS;

  // Gain format: unsigned fixed point, 1.0 = 2^GAIN_FRAC_BITS
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

  // Sample path widths
  localparam int SAMPLE_W       = 16;
  localparam int SUM_W          = SAMPLE_W + 1;
  localparam int PROD_W         = SUM_W + GAIN_W;
  localparam int QUOT_W         = PROD_W - GAIN_FRAC_BITS;

  // Configuration port
  localparam int SETUP_W        = 20;
  localparam int CFG_IDX_W      = 3;
  localparam logic [SETUP_W-1:0] SETUP_RESET = 20'h9FFFF;

  // Volume codes
  localparam int CODE_W         = 8;
  localparam int ROM_DEPTH      = 256;
  localparam int CODE_UNITY     = 255;

  // Saturation limits
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;
  localparam logic [QUOT_W-1:0]   LIM_POS = QUOT_W'(32767);
  localparam logic [QUOT_W-1:0]   LIM_NEG = QUOT_W'(32768);

  // Port numbering inside a lane
  localparam int PORT_LEFT      = 0;
  localparam int PORT_RIGHT     = 1;

  // ln 2 in Q30
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // Per-drive setup register, as packed in the register word
  typedef struct packed {
    logic [1:0]        sel_right;
    logic [1:0]        sel_left;
    logic [CODE_W-1:0] code_right;
    logic [CODE_W-1:0] code_left;
  } drive_setup_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [1:0][SAMPLE_W-1:0]   port_pair_t;
  typedef logic [ROM_DEPTH-1:0][GAIN_W-1:0] gain_rom_t;

  // One table entry: log2 by repeated squaring, then 1 + (20/48)*ln(c/256)
  function automatic logic [GAIN_W-1:0] vol_gain(int unsigned c);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] d;
    logic [63:0] loss;
    logic [63:0] g60;
    logic [63:0] g;
    int          n;
    int          i;
    int          k;
    g = 64'd0;
    if (c == CODE_UNITY) begin
      g = 64'd1 << GAIN_FRAC_BITS;
    end else if (c > 0) begin
      n = 0;
      for (i = 1; i < CODE_W; i++) begin
        if ((c >> i) != 0) n = i;
      end
      x = (64'(c) << 31) >> n;
      r = 64'(n) << 30;
      for (k = 29; k >= 0; k--) begin
        x = (x * x) >> 31;
        if (x >= (64'd2 << 31)) begin
          x    = x >> 1;
          r[k] = 1'b1;
        end
      end
      d    = (64'd8 << 30) - r;
      loss = ((d * LN2_Q30) / 12) * 5;
      // Small codes would go negative: clamp to zero
      if (loss < (64'd1 << 60)) begin
        g60 = (64'd1 << 60) - loss;
        g   = (g60 + (64'd1 << (59 - GAIN_FRAC_BITS))) >> (60 - GAIN_FRAC_BITS);
      end
    end
    return g[GAIN_W-1:0];
  endfunction

  function automatic gain_rom_t build_rom();
    gain_rom_t rom;
    int        c;
    for (c = 0; c < ROM_DEPTH; c++) begin
      rom[c] = vol_gain(c);
    end
    return rom;
  endfunction

  localparam gain_rom_t VOL_ROM = build_rom();

endpackage

// ===== rtl/cdm_lane.sv =====
// ---------------------------------------------------------------------------
// cdm_lane
// One drive lane: source select, volume lookup, gain multiply, saturation.
// ---------------------------------------------------------------------------
module cdm_lane (
  input  logic                  clk,
  input  logic                  active,
  input  cdm_pkg::drive_setup_t setup,
  input  cdm_pkg::sample_t      src_a,
  input  cdm_pkg::sample_t      src_b,
  output cdm_pkg::port_pair_t   scaled
);

  logic [1:0][cdm_pkg::SUM_W-1:0]  mag_nxt;
  logic [1:0][cdm_pkg::SUM_W-1:0]  mag_r;
  logic [1:0]                      neg_nxt;
  logic [1:0]                      neg_r;
  logic [1:0][cdm_pkg::GAIN_W-1:0] gain_nxt;
  logic [1:0][cdm_pkg::GAIN_W-1:0] gain_r;
  cdm_pkg::port_pair_t             scaled_nxt;
  cdm_pkg::port_pair_t             scaled_r;

  // Stage 1: pick sources, take magnitude, look up gain
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      logic [1:0]                    sel;
      logic [cdm_pkg::CODE_W-1:0]    code;
      logic signed [cdm_pkg::SUM_W-1:0] sum;
      sel  = (p == cdm_pkg::PORT_RIGHT) ? setup.sel_right  : setup.sel_left;
      code = (p == cdm_pkg::PORT_RIGHT) ? setup.code_right : setup.code_left;
      sum  = '0;
      if (active && sel[0]) sum = sum + cdm_pkg::SUM_W'(src_a);
      if (active && sel[1]) sum = sum + cdm_pkg::SUM_W'(src_b);
      neg_nxt[p]  = sum[cdm_pkg::SUM_W-1];
      mag_nxt[p]  = sum[cdm_pkg::SUM_W-1] ? cdm_pkg::SUM_W'(-sum) : cdm_pkg::SUM_W'(sum);
      gain_nxt[p] = cdm_pkg::VOL_ROM[code];
    end
  end

  // Stage 2: multiply, truncate toward zero, clamp to 16 bits
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      logic [cdm_pkg::PROD_W-1:0] prod;
      logic [cdm_pkg::QUOT_W-1:0] q;
      prod = cdm_pkg::PROD_W'(mag_r[p]) * cdm_pkg::PROD_W'(gain_r[p]);
      q    = prod[cdm_pkg::PROD_W-1:cdm_pkg::GAIN_FRAC_BITS];
      if (neg_r[p]) begin
        scaled_nxt[p] = (q > cdm_pkg::LIM_NEG) ? cdm_pkg::SAT_NEG
                                               : cdm_pkg::SAMPLE_W'(~q + 1'b1);
      end else begin
        scaled_nxt[p] = (q > cdm_pkg::LIM_POS) ? cdm_pkg::SAT_POS
                                               : q[cdm_pkg::SAMPLE_W-1:0];
      end
    end
  end

  // Payload registers, loaded every cycle
  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    gain_r   <= gain_nxt;
    scaled_r <= scaled_nxt;
  end

  assign scaled = scaled_r;

endmodule

// ===== rtl/cdm_merge.sv =====
// ---------------------------------------------------------------------------
// cdm_merge
// Sums the lane results per port with 16-bit wrap into one stereo frame.
// ---------------------------------------------------------------------------
module cdm_merge (
  input  logic                clk,
  input  cdm_pkg::port_pair_t lane_val [cdm_pkg::LANE_COUNT],
  output cdm_pkg::port_pair_t mix
);

  cdm_pkg::port_pair_t mix_nxt;
  cdm_pkg::port_pair_t mix_r;

  // Wrapping sum across lanes
  always_comb begin
    mix_nxt = '0;
    for (int k = 0; k < cdm_pkg::LANE_COUNT; k++) begin
      mix_nxt[cdm_pkg::PORT_LEFT]  = mix_nxt[cdm_pkg::PORT_LEFT]
                                   + lane_val[k][cdm_pkg::PORT_LEFT];
      mix_nxt[cdm_pkg::PORT_RIGHT] = mix_nxt[cdm_pkg::PORT_RIGHT]
                                   + lane_val[k][cdm_pkg::PORT_RIGHT];
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
  end

  assign mix = mix_r;

endmodule

// ===== rtl/cd_audio_drive_mixer.sv =====
// ---------------------------------------------------------------------------
// cd_audio_drive_mixer
// Four-drive optical audio mixer with per-drive routing and log volume.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | start / busy         | in_drive_active, in_dN_left/right
//  result   | out_strobe           | out_mix_left, out_mix_right
//  config   | cfg_we               | cfg_index, cfg_wdata
//
//  An item is taken every cycle; busy stays low. Each item passes through
//  registered stages: select and volume lookup, the 17x17 gain multiply with
//  clamp, then the wrapping merge of the drive lanes. Throughput is set by
//  these registered stages, one item per cycle. Synchronous active-low reset
//  clears the item valid pipeline and loads the setup registers with their
//  default. Results are not held: out_strobe marks each for a single cycle.
// ---------------------------------------------------------------------------
module cd_audio_drive_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      in_drive_active,
  input  logic signed [15:0]              in_d0_left,
  input  logic signed [15:0]              in_d0_right,
  input  logic signed [15:0]              in_d1_left,
  input  logic signed [15:0]              in_d1_right,
  input  logic signed [15:0]              in_d2_left,
  input  logic signed [15:0]              in_d2_right,
  input  logic signed [15:0]              in_d3_left,
  input  logic signed [15:0]              in_d3_right,
  // result channel
  output logic                            out_strobe,
  output logic signed [15:0]              out_mix_left,
  output logic signed [15:0]              out_mix_right,
  // configuration
  input  logic                            cfg_we,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdm_pkg::SETUP_W-1:0]     cfg_wdata
);

  logic [cdm_pkg::SETUP_W-1:0] setup_r [cdm_pkg::DRIVE_PORTS];
  cdm_pkg::sample_t            src_a   [cdm_pkg::DRIVE_PORTS];
  cdm_pkg::sample_t            src_b   [cdm_pkg::DRIVE_PORTS];
  cdm_pkg::port_pair_t         lane_val [cdm_pkg::LANE_COUNT];
  cdm_pkg::port_pair_t         mix;
  logic                        accept;
  logic [2:0]                  valid_r;
  logic [2:0]                  valid_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Setup registers; writes beyond the last drive are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < cdm_pkg::DRIVE_PORTS; k++) setup_r[k] <= cdm_pkg::SETUP_RESET;
    end else if (cfg_we && (cfg_index < cdm_pkg::CFG_IDX_W'(cdm_pkg::DRIVE_PORTS))) begin
      setup_r[cfg_index[1:0]] <= cfg_wdata;
    end
  end

  // Item valid pipeline, one bit per stage
  assign valid_nxt = {valid_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Source samples per drive
  assign src_a[0] = in_d0_left;
  assign src_b[0] = in_d0_right;
  assign src_a[1] = in_d1_left;
  assign src_b[1] = in_d1_right;
  assign src_a[2] = in_d2_left;
  assign src_b[2] = in_d2_right;
  assign src_a[3] = in_d3_left;
  assign src_b[3] = in_d3_right;

  // Drive lanes
  for (genvar k = 0; k < cdm_pkg::LANE_COUNT; k++) begin : g_lane
    cdm_lane u_lane (
      .clk    (clk),
      .active (in_drive_active[k]),
      .setup  (cdm_pkg::drive_setup_t'(setup_r[k])),
      .src_a  (src_a[k]),
      .src_b  (src_b[k]),
      .scaled (lane_val[k])
    );
  end

  // Merge of the lanes
  cdm_merge u_merge (
    .clk      (clk),
    .lane_val (lane_val),
    .mix      (mix)
  );

  assign out_strobe    = valid_r[2];
  assign out_mix_left  = mix[cdm_pkg::PORT_LEFT];
  assign out_mix_right = mix[cdm_pkg::PORT_RIGHT];

  `include "cd_audio_drive_mixer_assert.svh"

  // A result is strobed for each item taken, and only for such items
  `CDM_ASSERT_NOW(a_strobe_latency, out_strobe, $past(accept, 3))
  `CDM_ASSERT_NOW(a_no_phantom, $past(accept, 3), out_strobe)
  // A frame with no drive playing mixes to silence
  `CDM_ASSERT_NOW(a_silent_mix, out_strobe && ($past(in_drive_active, 3) == 4'd0), (out_mix_left == 16'sd0) && (out_mix_right == 16'sd0))

endmodule

// ===== test/cd_audio_drive_mixer_check.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cd_audio_drive_mixer_check
// Watches the mixer's channels and predicts every mixed frame.
// It keeps its own copy of the drive setup registers and its own log volume
// table. Each accepted item is turned into an expected stereo mix. Each
// strobed result is compared field by field with the oldest expected mix.
// ---------------------------------------------------------------------------
module cd_audio_drive_mixer_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [3:0]                    in_drive_active,
  input  logic signed [15:0]            in_d0_left,
  input  logic signed [15:0]            in_d0_right,
  input  logic signed [15:0]            in_d1_left,
  input  logic signed [15:0]            in_d1_right,
  input  logic signed [15:0]            in_d2_left,
  input  logic signed [15:0]            in_d2_right,
  input  logic signed [15:0]            in_d3_left,
  input  logic signed [15:0]            in_d3_right,
  input  logic                          out_strobe,
  input  logic signed [15:0]            out_mix_left,
  input  logic signed [15:0]            out_mix_right,
  input  logic                          cfg_we,
  input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdm_pkg::SETUP_W-1:0]   cfg_wdata,
  output int                            mismatches,
  output int                            mixes_checked,
  output int                            mix_backlog
);

  // Setup registers that exist; writes to higher indexes are dropped
  localparam int SETUP_REG_COUNT = 4;

  typedef struct packed {
    logic [3:0]        active;
    logic [3:0][15:0]  left;
    logic [3:0][15:0]  right;
  } frame_t;

  typedef struct packed {
    logic [15:0] mix_left;
    logic [15:0] mix_right;
  } mix_t;

  cdm_pkg::drive_setup_t      setups [SETUP_REG_COUNT];
  logic [cdm_pkg::GAIN_W-1:0] gain_table [cdm_pkg::ROM_DEPTH];
  mix_t                       pending_mixes [$];

  // Log volume gain of one code: 1 + (20/48) * ln(code/256), clamped at zero
  function automatic logic [cdm_pkg::GAIN_W-1:0] gain_of_code(int unsigned code);
    longint unsigned mant;
    longint unsigned lg;
    longint unsigned span;
    longint unsigned loss;
    longint unsigned g60;
    longint unsigned g;
    int              msb;
    int              k;
    g = 0;
    if (code == cdm_pkg::CODE_UNITY) begin
      g = 64'd1 << cdm_pkg::GAIN_FRAC_BITS;
    end else if (code != 0) begin
      msb = 0;
      for (k = 1; k < cdm_pkg::CODE_W; k++) begin
        if ((code >> k) != 0) msb = k;
      end
      // log2 in Q30: mantissa in Q31, squared and truncated bit by bit
      mant = (64'(code) << 31) >> msb;
      lg   = 64'(msb) << 30;
      for (k = 29; k >= 0; k--) begin
        mant = (mant * mant) >> 31;
        if (mant >= (64'd2 << 31)) begin
          mant = mant >> 1;
          lg   = lg | (64'd1 << k);
        end
      end
      span = (64'd8 << 30) - lg;
      loss = ((span * cdm_pkg::LN2_Q30) / 12) * 5;
      // small codes would give a negative gain: left at zero
      if (loss < (64'd1 << 60)) begin
        g60 = (64'd1 << 60) - loss;
        g   = (g60 + (64'd1 << (59 - cdm_pkg::GAIN_FRAC_BITS)))
              >> (60 - cdm_pkg::GAIN_FRAC_BITS);
      end
    end
    return g[cdm_pkg::GAIN_W-1:0];
  endfunction

  initial begin
    for (int c = 0; c < cdm_pkg::ROM_DEPTH; c++) gain_table[c] = gain_of_code(c);
  end

  // One port of one drive: routed sum, gain, truncation toward zero, clamp
  function automatic logic [15:0] scaled_port(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic [1:0] sel,
                                              input logic [cdm_pkg::GAIN_W-1:0] gain);
    longint          sum;
    longint          q;
    longint unsigned mag;
    if (gain == 0 || sel == 2'b00) return 16'h0000;
    sum = 0;
    if (sel[0]) sum = sum + a;
    if (sel[1]) sum = sum + b;
    if (sum < 0) begin
      mag = -sum;
      mag = (mag * gain) >> cdm_pkg::GAIN_FRAC_BITS;
      q   = -longint'(mag);
    end else begin
      mag = sum;
      mag = (mag * gain) >> cdm_pkg::GAIN_FRAC_BITS;
      q   = longint'(mag);
    end
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Mixed frame: active drive lanes summed with 16-bit wrap
  function automatic mix_t predict_mix(frame_t f);
    mix_t                  m;
    cdm_pkg::drive_setup_t s;
    logic [15:0]           acc_l;
    logic [15:0]           acc_r;
    int                    k;
    acc_l = 16'h0000;
    acc_r = 16'h0000;
    for (k = 0; k < cdm_pkg::LANE_COUNT; k++) begin
      s = setups[k];
      if (f.active[k]) begin
        acc_l = acc_l + scaled_port(f.left[k], f.right[k], s.sel_left,
                                    gain_table[s.code_left]);
        acc_r = acc_r + scaled_port(f.left[k], f.right[k], s.sel_right,
                                    gain_table[s.code_right]);
      end
    end
    m.mix_left  = acc_l;
    m.mix_right = acc_r;
    return m;
  endfunction

  // Channel monitor: predict on accept, compare on strobe, track writes
  always @(posedge clk) begin
    frame_t f;
    mix_t   want;
    if (!rst_n) begin
      for (int k = 0; k < SETUP_REG_COUNT; k++) setups[k] = cdm_pkg::SETUP_RESET;
      pending_mixes.delete();
      mismatches    = 0;
      mixes_checked = 0;
    end else begin
      if (start && !busy) begin
        f.active   = in_drive_active;
        f.left[0]  = in_d0_left;
        f.right[0] = in_d0_right;
        f.left[1]  = in_d1_left;
        f.right[1] = in_d1_right;
        f.left[2]  = in_d2_left;
        f.right[2] = in_d2_right;
        f.left[3]  = in_d3_left;
        f.right[3] = in_d3_right;
        pending_mixes.push_back(predict_mix(f));
      end
      if (out_strobe) begin
        if (pending_mixes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected mix: left %0d right %0d with no item waiting",
                     out_mix_left, out_mix_right);
        end else begin
          want = pending_mixes.pop_front();
          if (out_mix_left !== want.mix_left || out_mix_right !== want.mix_right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mix %0d wrong: left expected %0d got %0d, right expected %0d got %0d",
                       mixes_checked, $signed(want.mix_left), out_mix_left,
                       $signed(want.mix_right), out_mix_right);
          end
          mixes_checked++;
        end
      end
      if (cfg_we && cfg_index < SETUP_REG_COUNT) setups[cfg_index[1:0]] = cfg_wdata;
    end
    mix_backlog <= pending_mixes.size();
  end

endmodule

// ===== test/cd_audio_drive_mixer_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cd_audio_drive_mixer_test
// Stimulus and verdict for the four-drive audio mixer.
// A directed run covers sample extremes, routing, saturation, wrap, zero and
// clamped gains and ignored register writes; random frames follow under a
// range of drive setups and sender idling patterns. The checker beside the
// block predicts and compares every mixed frame.
// ---------------------------------------------------------------------------
module cd_audio_drive_mixer_test;

  typedef enum logic [cdm_pkg::CFG_IDX_W-1:0] {
    REG_DRIVE0 = 3'd0,
    REG_DRIVE1 = 3'd1,
    REG_DRIVE2 = 3'd2,
    REG_DRIVE3 = 3'd3
  } reg_index_t;

  localparam int REG_INDEX_MAX = (1 << cdm_pkg::CFG_IDX_W) - 1;
  localparam int MAX_POS       = 32767;
  localparam int MAX_NEG       = -32768;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [3:0]                    in_drive_active;
  logic signed [15:0]            in_d0_left;
  logic signed [15:0]            in_d0_right;
  logic signed [15:0]            in_d1_left;
  logic signed [15:0]            in_d1_right;
  logic signed [15:0]            in_d2_left;
  logic signed [15:0]            in_d2_right;
  logic signed [15:0]            in_d3_left;
  logic signed [15:0]            in_d3_right;
  logic                          out_strobe;
  logic signed [15:0]            out_mix_left;
  logic signed [15:0]            out_mix_right;
  logic                          cfg_we;
  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cdm_pkg::SETUP_W-1:0]   cfg_wdata;

  int mismatches;
  int mixes_checked;
  int mix_backlog;
  int idle_pct;
  int frames_sent;
  int settings_applied;

  cd_audio_drive_mixer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_drive_active (in_drive_active),
    .in_d0_left      (in_d0_left),
    .in_d0_right     (in_d0_right),
    .in_d1_left      (in_d1_left),
    .in_d1_right     (in_d1_right),
    .in_d2_left      (in_d2_left),
    .in_d2_right     (in_d2_right),
    .in_d3_left      (in_d3_left),
    .in_d3_right     (in_d3_right),
    .out_strobe      (out_strobe),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  cd_audio_drive_mixer_check mix_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_drive_active (in_drive_active),
    .in_d0_left      (in_d0_left),
    .in_d0_right     (in_d0_right),
    .in_d1_left      (in_d1_left),
    .in_d1_right     (in_d1_right),
    .in_d2_left      (in_d2_left),
    .in_d2_right     (in_d2_right),
    .in_d3_left      (in_d3_left),
    .in_d3_right     (in_d3_right),
    .out_strobe      (out_strobe),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .mixes_checked   (mixes_checked),
    .mix_backlog     (mix_backlog)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic cdm_pkg::drive_setup_t setup_word(int code_l, int code_r,
                                                       int sel_l, int sel_r);
    cdm_pkg::drive_setup_t s;
    s.code_left  = cdm_pkg::CODE_W'(code_l);
    s.code_right = cdm_pkg::CODE_W'(code_r);
    s.sel_left   = 2'(sel_l);
    s.sel_right  = 2'(sel_r);
    return s;
  endfunction

  // Codes weighted towards zero, unity and the clamped low range
  function automatic int rand_code();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return cdm_pkg::CODE_UNITY;
      2:       return $urandom_range(1, 23);
      3:       return $urandom_range(cdm_pkg::CODE_UNITY - 2, cdm_pkg::CODE_UNITY - 1);
      default: return $urandom_range(0, cdm_pkg::ROM_DEPTH - 1);
    endcase
  endfunction

  function automatic cdm_pkg::drive_setup_t rand_setup();
    return setup_word(rand_code(), rand_code(), $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  // Samples weighted towards the extremes
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'(MAX_POS);
      1:       return 16'(MAX_NEG);
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Loads all four drive setups, optionally followed by a stray write above
  // the last register, which the block must drop
  task automatic load_setups(input cdm_pkg::drive_setup_t s0,
                             input cdm_pkg::drive_setup_t s1,
                             input cdm_pkg::drive_setup_t s2,
                             input cdm_pkg::drive_setup_t s3,
                             input bit stray);
    cdm_pkg::drive_setup_t vals [4];
    vals[0] = s0;
    vals[1] = s1;
    vals[2] = s2;
    vals[3] = s3;
    for (int i = REG_DRIVE0; i <= REG_DRIVE3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cdm_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    if (stray) begin
      cfg_index <= cdm_pkg::CFG_IDX_W'($urandom_range(REG_DRIVE3 + 1, REG_INDEX_MAX));
      cfg_wdata <= cdm_pkg::SETUP_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // One item; start stays high afterwards so the next item can follow
  task automatic send_frame(input logic [3:0] active, input logic [7:0][15:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_drive_active <= 4'($urandom);
      @(posedge clk);
    end
    start           <= 1'b1;
    in_drive_active <= active;
    in_d0_left      <= s[0];
    in_d0_right     <= s[1];
    in_d1_left      <= s[2];
    in_d1_right     <= s[3];
    in_d2_left      <= s[4];
    in_d2_right     <= s[5];
    in_d3_left      <= s[6];
    in_d3_right     <= s[7];
    @(posedge clk);
    while (busy) @(posedge clk);
    frames_sent++;
  endtask

  // Every drive gets the same pair of source samples
  task automatic send_pair(input logic [3:0] active, input int left_v, input int right_v);
    send_frame(active, {4{16'(right_v), 16'(left_v)}});
  endtask

  // Stop sending, wait for all mixes, then cover the pipeline latency
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (mix_backlog != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [7:0][15:0] s;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_drive_active  <= 4'h0;
    in_d0_left       <= 16'h0000;
    in_d0_right      <= 16'h0000;
    in_d1_left       <= 16'h0000;
    in_d1_right      <= 16'h0000;
    in_d2_left       <= 16'h0000;
    in_d2_right      <= 16'h0000;
    in_d3_left       <= 16'h0000;
    in_d3_right      <= 16'h0000;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    idle_pct         = 0;
    frames_sent      = 0;
    settings_applied = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setups: left takes channel 0, right channel 1, both at unity
    send_pair(4'h0, MAX_POS, MAX_NEG);
    send_pair(4'hF, 0, 0);
    send_pair(4'h1, MAX_POS, MAX_NEG);
    send_pair(4'h2, MAX_NEG, MAX_POS);
    send_pair(4'h4, -1, 1);
    send_pair(4'h8, 16'h5555, 16'hAAAA);
    send_pair(4'hF, MAX_POS, MAX_POS);
    send_pair(4'hF, MAX_NEG, MAX_NEG);
    send_pair(4'hF, 16'hAAAA, 16'h5555);
    drain();

    // Both channels summed at unity: saturation both ways
    load_setups(setup_word(255, 255, 3, 3), setup_word(255, 255, 3, 3),
                setup_word(255, 255, 3, 3), setup_word(255, 255, 3, 3), 1'b0);
    send_pair(4'h1, MAX_POS, MAX_POS);
    send_pair(4'h1, MAX_NEG, MAX_NEG);
    send_pair(4'h3, MAX_POS, MAX_NEG);
    send_pair(4'hF, -1, -1);
    send_pair(4'hF, MAX_POS, MAX_POS);
    drain();

    // Zero gain, zero select, clamped small code and a mid code, then a
    // stray write that must leave them alone
    load_setups(setup_word(0, 0, 3, 3), setup_word(255, 255, 0, 0),
                setup_word(10, 23, 3, 1), setup_word(128, 200, 1, 2), 1'b1);
    send_pair(4'h1, MAX_POS, MAX_NEG);
    send_pair(4'h2, MAX_NEG, MAX_POS);
    send_pair(4'h4, MAX_POS, MAX_POS);
    send_pair(4'h8, MAX_NEG, MAX_POS);
    send_pair(4'h8, 12345, -2345);
    send_pair(4'hF, MAX_NEG, MAX_NEG);
    drain();

    // Random frames under changing setups and idling
    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        0:       load_setups('0, '0, '0, '0, 1'b0);
        1:       load_setups('1, '1, '1, '1, 1'b1);
        default: load_setups(rand_setup(), rand_setup(), rand_setup(), rand_setup(),
                             1'($urandom_range(0, 1)));
      endcase
      case (blk % 4)
        1:       idle_pct = 68;
        3:       idle_pct = 14;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 56; n++) begin
        for (int j = 0; j < 8; j++) s[j] = rand_sample();
        send_frame(($urandom_range(0, 7) == 0) ? 4'hF : 4'($urandom), s);
      end
      drain();
    end

    $display("Mixed %0d frames under %0d drive setups with varied idling; %0d mixes checked",
             frames_sent, settings_applied, mixes_checked);
    if (mismatches == 0 && mix_backlog == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
